// ----- rtl/axis_rotation_error_angle_macros.svh -----
// Assertion macros for the axis rotation error angle block.
// No dependencies; included by the files that carry assertions.
`ifndef AXIS_ROTATION_ERROR_ANGLE_MACROS_SVH
`define AXIS_ROTATION_ERROR_ANGLE_MACROS_SVH

// same-cycle implication, disabled in reset
`define AERR_ASSERT_SAME(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("aerr: same-cycle property violated");

// next-cycle implication, disabled in reset
`define AERR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("aerr: next-cycle property violated");

`endif

// ----- rtl/aerr_pkg.sv -----
// Shared types and fixed-point constants of the axis rotation error angle block.
// No dependencies.
package aerr_pkg;

	localparam int COMP_W      = 16;
	localparam int MARGIN_W    = 21;
	localparam logic [MARGIN_W-1:0] MARGIN_RESET = 21'd1074;
	localparam int ANGLE_W     = 16;

	// clamped dot product, Q2.30 signed
	localparam int DOT_FRAC    = 30;
	localparam int DOT_W       = DOT_FRAC + 2;

	// sine term from the square root, Q1.40 unsigned
	localparam int ROOT_FRAC   = 40;
	localparam int ROOT_W      = ROOT_FRAC + 1;
	localparam int RAD_W       = 2 * ROOT_FRAC + 1;

	// vectoring datapath
	localparam int VEC_FRAC    = 42;
	localparam int VEC_W       = VEC_FRAC + 3;
	localparam int ITERS       = VEC_FRAC;
	localparam int ANGLE_GUARD = 24;

	localparam real PI = 3.14159265358979323846;

	typedef struct packed {
		logic signed [COMP_W-1:0] ref_axis_x;
		logic signed [COMP_W-1:0] ref_axis_y;
		logic signed [COMP_W-1:0] ref_axis_z;
		logic signed [COMP_W-1:0] est_axis_x;
		logic signed [COMP_W-1:0] est_axis_y;
		logic signed [COMP_W-1:0] est_axis_z;
	} axis_pair_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] angle_degrees;
		logic               near_aligned;
	} angle_result_t;

	typedef struct packed {
		logic valid;
		logic near;
	} pipe_tag_t;

endpackage

// ----- rtl/axis_rotation_error_angle.sv -----
// Axis rotation error angle: acos of the dot of two z-axis images, in degree codes.
// Accepts one transfer per cycle while in_stall is low.
// Stages: 5 dot/radicand, 41 square root bits, 44 CORDIC; a skid register holds
// one result while the output stalls. Reset clears all valid bits and loads the
// margin register with 1074. Depends on aerr_pkg, aerr_dot, aerr_sqrt, aerr_cordic.
`include "axis_rotation_error_angle_macros.svh"

module axis_rotation_error_angle
	import aerr_pkg::*;
#(
	parameter int ANGLE_FRAC_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  axis_pair_t          in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output angle_result_t       out_data,
	input  logic                cfg_wr_en,
	input  logic [MARGIN_W-1:0] cfg_wr_data
);

	localparam int  FULL_INT  = 180 << ANGLE_FRAC_BITS;
	localparam bit  FULL_FITS = FULL_INT < (1 << ANGLE_W);

	logic [MARGIN_W-1:0]     margin_q;
	logic                    adv;

	pipe_tag_t               dot_tag, sq_tag;
	logic signed [DOT_W-1:0] dot_dot, sq_dot;
	logic [RAD_W-1:0]        radicand;
	logic [ROOT_W-1:0]       root;
	logic                    res_valid;
	angle_result_t           res;

	logic                    out_valid_q, skid_valid_q;
	angle_result_t           out_q, skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= MARGIN_RESET;
		end else if (cfg_wr_en) begin
			margin_q <= cfg_wr_data;
		end
	end

	// advance the whole pipeline unless the skid register is occupied
	assign adv      = !skid_valid_q;
	assign in_stall = skid_valid_q;

	aerr_dot u_dot (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (in_valid),
		.in_data  (in_data),
		.margin   (margin_q),
		.tag      (dot_tag),
		.dot      (dot_dot),
		.radicand (radicand)
	);

	aerr_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_tag   (dot_tag),
		.in_dot   (dot_dot),
		.radicand (radicand),
		.tag      (sq_tag),
		.dot      (sq_dot),
		.root     (root)
	);

	aerr_cordic #(
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_tag    (sq_tag),
		.in_dot    (sq_dot),
		.root      (root),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && out_stall) begin
			if (adv && res_valid) begin
				skid_valid_q <= 1'b1;
			end
		end else if (skid_valid_q) begin
			out_valid_q  <= 1'b1;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid_q <= adv && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && out_stall) begin
			if (adv && res_valid) begin
				skid_q <= res;
			end
		end else if (skid_valid_q) begin
			out_q <= skid_q;
		end else if (adv && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`AERR_ASSERT_SAME(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q)
	`AERR_ASSERT_NEXT(a_skid_drains, clk, arst_n, !(out_valid_q && out_stall), !skid_valid_q)
	`AERR_ASSERT_SAME(a_near_zero, clk, arst_n, out_valid_q && out_q.near_aligned, out_q.angle_degrees == '0)
	`AERR_ASSERT_SAME(a_angle_range, clk, arst_n, out_valid_q && FULL_FITS, int'(out_q.angle_degrees) <= FULL_INT)

endmodule

// ----- rtl/aerr_dot.sv -----
// Dot product, clamp, near-one test and radicand 1 - dot^2 (five stages).
// Depends on aerr_pkg.
module aerr_dot
	import aerr_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  logic                   in_valid,
	input  axis_pair_t             in_data,
	input  logic [MARGIN_W-1:0]    margin,
	output pipe_tag_t              tag,
	output logic signed [DOT_W-1:0] dot,
	output logic [RAD_W-1:0]       radicand
);

	localparam int PROD_W    = 2 * COMP_W;
	localparam int PROD_FRAC = 2 * COMP_W - 2;
	localparam int SUM_W     = DOT_W + 1;
	localparam int WIDE_W    = SUM_W + PROD_W;
	localparam int SHL       = (PROD_FRAC <= DOT_FRAC) ? DOT_FRAC - PROD_FRAC : 0;
	localparam int SHR       = (PROD_FRAC > DOT_FRAC) ? PROD_FRAC - DOT_FRAC : 0;
	localparam int SQ_W      = 2 * DOT_W;
	localparam int RAD_SHIFT = 2 * ROOT_FRAC - 2 * DOT_FRAC;
	localparam logic signed [SUM_W-1:0] ONE = SUM_W'(1) << DOT_FRAC;
	localparam logic signed [SUM_W-1:0] NEG_ONE = -ONE;
	localparam logic [SQ_W-1:0] ONE_SQ = SQ_W'(1) << (2 * DOT_FRAC);

	pipe_tag_t                tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
	logic signed [PROD_W-1:0] prod_s1 [3];
	logic signed [SUM_W-1:0]  sum_s2;
	logic signed [DOT_W-1:0]  dot_s3, dot_s4, dot_s5;
	logic [SQ_W-1:0]          sq_s4;
	logic [RAD_W-1:0]         rad_s5;

	logic signed [SUM_W-1:0]  sum_c;
	logic signed [DOT_W-1:0]  dot_c;
	logic signed [SUM_W-1:0]  limit_c;
	logic signed [SQ_W-1:0]   sq_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
		end else if (adv) begin
			tag_s1 <= '{valid: in_valid, near: 1'b0};
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= '{valid: tag_s3.valid, near: $signed(SUM_W'(dot_s3)) > limit_c};
			tag_s5 <= tag_s4;
		end
	end

	always_comb begin
		logic signed [WIDE_W-1:0] wide;
		sum_c = '0;
		for (int i = 0; i < 3; i++) begin
			wide  = WIDE_W'(prod_s1[i]);
			wide  = (wide <<< SHL) >>> SHR;
			sum_c = sum_c + $signed(wide[SUM_W-1:0]);
		end
	end

	always_comb begin
		if (sum_s2 > ONE) begin
			dot_c = $signed(ONE[DOT_W-1:0]);
		end else if (sum_s2 < NEG_ONE) begin
			dot_c = $signed(NEG_ONE[DOT_W-1:0]);
		end else begin
			dot_c = $signed(sum_s2[DOT_W-1:0]);
		end
	end

	assign limit_c = ONE - $signed(SUM_W'(margin));
	assign sq_c    = dot_s3 * dot_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1[0] <= $signed(in_data.ref_axis_x) * $signed(in_data.est_axis_x);
			prod_s1[1] <= $signed(in_data.ref_axis_y) * $signed(in_data.est_axis_y);
			prod_s1[2] <= $signed(in_data.ref_axis_z) * $signed(in_data.est_axis_z);
			sum_s2     <= sum_c;
			dot_s3     <= dot_c;
			dot_s4     <= dot_s3;
			sq_s4      <= sq_c;
			dot_s5     <= dot_s4;
			rad_s5     <= RAD_W'(ONE_SQ - sq_s4) << RAD_SHIFT;
		end
	end

	assign tag      = tag_s5;
	assign dot      = dot_s5;
	assign radicand = rad_s5;

endmodule

// ----- rtl/aerr_sqrt.sv -----
// Pipelined restoring square root, one root bit per stage, floor result in Q1.40.
// Depends on aerr_pkg.
module aerr_sqrt
	import aerr_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  pipe_tag_t               in_tag,
	input  logic signed [DOT_W-1:0] in_dot,
	input  logic [RAD_W-1:0]        radicand,
	output pipe_tag_t               tag,
	output logic signed [DOT_W-1:0] dot,
	output logic [ROOT_W-1:0]       root
);

	pipe_tag_t               tag_s  [ROOT_W];
	logic signed [DOT_W-1:0] dot_s  [ROOT_W];
	logic [RAD_W:0]          rem_s  [ROOT_W];
	logic [ROOT_W-1:0]       root_s [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_bit
		localparam int B = ROOT_W - 1 - k;

		pipe_tag_t               tag_in;
		logic signed [DOT_W-1:0] dot_in;
		logic [RAD_W:0]          rem_in;
		logic [ROOT_W-1:0]       root_in;
		logic [RAD_W:0]          trial;

		if (k == 0) begin : g_first
			assign tag_in  = in_tag;
			assign dot_in  = in_dot;
			assign rem_in  = (RAD_W+1)'(radicand);
			assign root_in = '0;
		end else begin : g_next
			assign tag_in  = tag_s[k-1];
			assign dot_in  = dot_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
		end

		assign trial = ((RAD_W+1)'(root_in) << (B + 1)) | ((RAD_W+1)'(1) << (2 * B));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[k] <= '0;
			end else if (adv) begin
				tag_s[k] <= tag_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dot_s[k] <= dot_in;
				if (rem_in >= trial) begin
					rem_s[k]  <= rem_in - trial;
					root_s[k] <= root_in | (ROOT_W'(1) << B);
				end else begin
					rem_s[k]  <= rem_in;
					root_s[k] <= root_in;
				end
			end
		end
	end

	assign tag  = tag_s[ROOT_W-1];
	assign dot  = dot_s[ROOT_W-1];
	assign root = root_s[ROOT_W-1];

endmodule

// ----- rtl/aerr_cordic.sv -----
// Vectoring CORDIC on (dot, sqrt(1 - dot^2)) with the angle kept in degree codes,
// then rounding, clamping and the near-one override. Depends on aerr_pkg.
module aerr_cordic
	import aerr_pkg::*;
#(
	parameter int ANGLE_FRAC_BITS = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  pipe_tag_t               in_tag,
	input  logic signed [DOT_W-1:0] in_dot,
	input  logic [ROOT_W-1:0]       root,
	output logic                    res_valid,
	output angle_result_t           res
);

	localparam int  ZSH       = ANGLE_FRAC_BITS + ANGLE_GUARD;
	localparam int  Z_W       = ZSH + 10;
	localparam int  DOT_SHIFT = VEC_FRAC - DOT_FRAC;
	localparam int  ROOT_SHIFT = VEC_FRAC - ROOT_FRAC;
	localparam real ZSCALE    = 180.0 * (2.0 ** ZSH);
	localparam logic signed [Z_W-1:0] Z_RIGHT   = Z_W'(90) <<< ZSH;
	localparam logic signed [Z_W-1:0] Z_HALF    = Z_W'(1) <<< (ANGLE_GUARD - 1);
	localparam logic signed [Z_W-1:0] FULL_CODE = Z_W'(180) <<< ANGLE_FRAC_BITS;

	function automatic logic signed [Z_W-1:0] atan_step(int i);
		real r;
		r = $atan(2.0 ** (-i)) * ZSCALE / PI;
		return Z_W'(longint'(r));
	endfunction

	pipe_tag_t               tag_s1, tag_s2;
	logic signed [VEC_W-1:0] x_s1, y_s1;
	logic signed [Z_W-1:0]   z_s1;
	pipe_tag_t               tag_s [ITERS];
	logic signed [VEC_W-1:0] x_s   [ITERS];
	logic signed [VEC_W-1:0] y_s   [ITERS];
	logic signed [Z_W-1:0]   z_s   [ITERS];
	angle_result_t           res_s2;

	logic signed [VEC_W-1:0] d_ext, r_ext;
	logic signed [Z_W-1:0]   z_rnd, code;
	angle_result_t           res_c;

	assign d_ext = VEC_W'(in_dot) <<< DOT_SHIFT;
	assign r_ext = $signed(VEC_W'(root) << ROOT_SHIFT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (adv) begin
			tag_s1 <= in_tag;
		end
	end

	// rotate by -90 degrees when the dot is negative
	always_ff @(posedge clk) begin
		if (adv) begin
			if (in_dot < 0) begin
				x_s1 <= r_ext;
				y_s1 <= -d_ext;
				z_s1 <= Z_RIGHT;
			end else begin
				x_s1 <= d_ext;
				y_s1 <= r_ext;
				z_s1 <= '0;
			end
		end
	end

	for (genvar i = 0; i < ITERS; i++) begin : g_iter
		localparam logic signed [Z_W-1:0] STEP = atan_step(i);

		pipe_tag_t               tag_in;
		logic signed [VEC_W-1:0] x_in, y_in;
		logic signed [Z_W-1:0]   z_in;

		if (i == 0) begin : g_first
			assign tag_in = tag_s1;
			assign x_in   = x_s1;
			assign y_in   = y_s1;
			assign z_in   = z_s1;
		end else begin : g_next
			assign tag_in = tag_s[i-1];
			assign x_in   = x_s[i-1];
			assign y_in   = y_s[i-1];
			assign z_in   = z_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[i] <= '0;
			end else if (adv) begin
				tag_s[i] <= tag_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (!y_in[VEC_W-1]) begin
					x_s[i] <= x_in + (y_in >>> i);
					y_s[i] <= y_in - (x_in >>> i);
					z_s[i] <= z_in + STEP;
				end else begin
					x_s[i] <= x_in - (y_in >>> i);
					y_s[i] <= y_in + (x_in >>> i);
					z_s[i] <= z_in - STEP;
				end
			end
		end
	end

	assign z_rnd = z_s[ITERS-1] + Z_HALF;
	assign code  = z_rnd >>> ANGLE_GUARD;

	always_comb begin
		res_c.near_aligned = tag_s[ITERS-1].near;
		if (tag_s[ITERS-1].near) begin
			res_c.angle_degrees = '0;
		end else if (code < 0) begin
			res_c.angle_degrees = '0;
		end else if (code > FULL_CODE) begin
			res_c.angle_degrees = ANGLE_W'(FULL_CODE);
		end else begin
			res_c.angle_degrees = ANGLE_W'(code);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else if (adv) begin
			tag_s2 <= tag_s[ITERS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_c;
		end
	end

	assign res_valid = tag_s2.valid;
	assign res       = res_s2;

endmodule

// ----- tb/angle_checker.sv -----
// Checker for the axis rotation error angle block: watches the input, output and
// margin ports, predicts each angle result and compares it field by field.
// Depends on aerr_pkg.
module angle_checker
	import aerr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  axis_pair_t          in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  angle_result_t       out_data,
	input  logic                cfg_wr_en,
	input  logic [MARGIN_W-1:0] cfg_wr_data,
	output int                  fail_count,
	output int                  pending
);

	localparam int          ANGLE_FRAC  = 8;
	localparam int          COS_TERMS   = 11;
	localparam longint      ONE_Q30     = 64'sd1 << 30;
	localparam logic [63:0] PI_Q61      = 64'h6487ED5110B4611A;
	localparam logic [63:0] HALF_PI_Q61 = PI_Q61 >> 1;
	localparam logic [63:0] FULL_CODE   = 64'd180 << ANGLE_FRAC;
	localparam logic [63:0] HALF_STEP   = PI_Q61 / (64'd2 * FULL_CODE);

	logic [MARGIN_W-1:0] margin_q = MARGIN_RESET;
	angle_result_t       angle_expected_q[$];
	angle_result_t       want;
	int                  fails = 0;

	function automatic logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
		logic [127:0] prod;
		prod = {64'd0, a} * {64'd0, b};
		return prod[125:62];
	endfunction

	// psi in [0, pi/2], Q61 radians; cosine in Q62
	function automatic longint cos_quadrant(logic [63:0] psi);
		logic [63:0] u;
		logic [63:0] u2;
		logic [63:0] term;
		logic [63:0] divisor;
		longint      sum;
		u    = psi << 1;
		u2   = q62_mul(u, u);
		term = 64'd1 << 62;
		sum  = longint'(term);
		for (int k = 1; k <= COS_TERMS; k++) begin
			divisor = 64'((2 * k - 1) * (2 * k));
			term    = q62_mul(term, u2) / divisor;
			if (k % 2 == 1)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		return sum;
	endfunction

	function automatic longint cos_angle(logic [63:0] phi);
		if (phi > HALF_PI_Q61)
			return -cos_quadrant(PI_Q61 - phi);
		return cos_quadrant(phi);
	endfunction

	function automatic angle_result_t predict_angle(axis_pair_t p, logic [MARGIN_W-1:0] margin);
		angle_result_t r;
		longint        dot;
		longint        target;
		logic [63:0]   lo;
		logic [63:0]   hi;
		logic [63:0]   mid;
		logic [63:0]   phi;
		dot = longint'(p.ref_axis_x) * longint'(p.est_axis_x)
			+ longint'(p.ref_axis_y) * longint'(p.est_axis_y)
			+ longint'(p.ref_axis_z) * longint'(p.est_axis_z);
		if (dot > ONE_Q30)
			dot = ONE_Q30;
		if (dot < -ONE_Q30)
			dot = -ONE_Q30;
		if (dot > ONE_Q30 - longint'(margin)) begin
			r.angle_degrees = '0;
			r.near_aligned  = 1'b1;
			return r;
		end
		// search the largest code whose lower half-step bound still has cos >= dot
		target = dot <<< 32;
		lo     = 64'd0;
		hi     = FULL_CODE;
		while (lo < hi) begin
			mid = (lo + hi + 64'd1) >> 1;
			phi = (64'd2 * mid - 64'd1) * HALF_STEP;
			if (cos_angle(phi) >= target)
				lo = mid;
			else
				hi = mid - 64'd1;
		end
		r.angle_degrees = lo[ANGLE_W-1:0];
		r.near_aligned  = 1'b0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= MARGIN_RESET;
			angle_expected_q.delete();
			pending  <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (angle_expected_q.size() == 0) begin
					$error("output transfer with no result expected: angle_degrees %0d",
						out_data.angle_degrees);
					fails++;
				end else begin
					want = angle_expected_q.pop_front();
					if (out_data.angle_degrees !== want.angle_degrees) begin
						$error("angle_degrees: expected %0d, got %0d",
							want.angle_degrees, out_data.angle_degrees);
						fails++;
					end
					if (out_data.near_aligned !== want.near_aligned) begin
						$error("near_aligned: expected %0d, got %0d",
							want.near_aligned, out_data.near_aligned);
						fails++;
					end
				end
			end
			if (in_valid && !in_stall)
				angle_expected_q.push_back(predict_angle(in_data, margin_q));
			if (cfg_wr_en)
				margin_q <= cfg_wr_data;
			pending    <= angle_expected_q.size();
			fail_count <= fails;
		end
	end

endmodule

// ----- tb/testbench.sv -----
// Top of the axis rotation error angle testbench: clock, reset, margin writes,
// directed and random pose pairs, output stalls and the verdict.
// Depends on aerr_pkg, axis_rotation_error_angle and angle_checker.
module testbench;
	import aerr_pkg::*;

	typedef struct packed {
		logic signed [COMP_W-1:0] x;
		logic signed [COMP_W-1:0] y;
		logic signed [COMP_W-1:0] z;
	} axis_vec_t;

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                in_valid    = 1'b0;
	logic                in_stall;
	axis_pair_t          in_data     = '0;
	logic                out_valid;
	logic                out_stall   = 1'b0;
	angle_result_t       out_data;
	logic                cfg_wr_en   = 1'b0;
	logic [MARGIN_W-1:0] cfg_wr_data = '0;
	int                  fail_count;
	int                  pending;

	int gap_pct   = 0;
	int stall_pct = 0;
	bit long_hold = 1'b0;

	always #5 clk = ~clk;

	axis_rotation_error_angle u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	angle_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	function automatic logic signed [COMP_W-1:0] sat16(int v);
		if (v > 32767)
			return 16'sd32767;
		if (v < -32768)
			return -16'sd32768;
		return 16'(v);
	endfunction

	function automatic axis_pair_t pair_of(int rx, int ry, int rz, int ex, int ey, int ez);
		axis_pair_t p;
		p.ref_axis_x = 16'(rx);
		p.ref_axis_y = 16'(ry);
		p.ref_axis_z = 16'(rz);
		p.est_axis_x = 16'(ex);
		p.est_axis_y = 16'(ey);
		p.est_axis_z = 16'(ez);
		return p;
	endfunction

	function automatic axis_vec_t unit_axis();
		axis_vec_t v;
		real       rx;
		real       ry;
		real       rz;
		real       n;
		rx = real'($urandom_range(0, 65535)) / 32767.5 - 1.0;
		ry = real'($urandom_range(0, 65535)) / 32767.5 - 1.0;
		rz = real'($urandom_range(0, 65535)) / 32767.5 - 1.0;
		n  = $sqrt(rx * rx + ry * ry + rz * rz);
		if (n < 1.0e-3) begin
			rx = 0.0;
			ry = 0.0;
			rz = 1.0;
			n  = 1.0;
		end
		v.x = sat16($rtoi(rx / n * 32767.0));
		v.y = sat16($rtoi(ry / n * 32767.0));
		v.z = sat16($rtoi(rz / n * 32767.0));
		return v;
	endfunction

	function automatic int jitter(int spread);
		return int'($urandom_range(0, 2 * spread)) - spread;
	endfunction

	// mostly near-aligned, anti-aligned and unit pairs; some raw bit noise
	function automatic axis_pair_t random_pair();
		axis_vec_t  r;
		axis_vec_t  e;
		axis_pair_t p;
		int         kind;
		int         spread;
		kind   = $urandom_range(0, 99);
		spread = 1 << $urandom_range(0, 11);
		r      = unit_axis();
		if (kind < 20) begin
			p = {$urandom(), $urandom(), $urandom()};
			return p;
		end else if (kind < 55) begin
			e.x = sat16(int'(r.x) + jitter(spread));
			e.y = sat16(int'(r.y) + jitter(spread));
			e.z = sat16(int'(r.z) + jitter(spread));
		end else if (kind < 70) begin
			e.x = sat16(-int'(r.x) + jitter(spread));
			e.y = sat16(-int'(r.y) + jitter(spread));
			e.z = sat16(-int'(r.z) + jitter(spread));
		end else begin
			e = unit_axis();
		end
		p.ref_axis_x = r.x;
		p.ref_axis_y = r.y;
		p.ref_axis_z = r.z;
		p.est_axis_x = e.x;
		p.est_axis_y = e.y;
		p.est_axis_z = e.z;
		return p;
	endfunction

	task automatic send_pair(axis_pair_t p);
		if ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_data  <= p;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic write_margin(logic [MARGIN_W-1:0] value);
		drain();
		cfg_wr_data <= value;
		cfg_wr_en   <= 1'b1;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	task automatic random_phase(logic [MARGIN_W-1:0] margin, int count, int gaps, int stalls,
			bit hold);
		write_margin(margin);
		gap_pct   = gaps;
		stall_pct = stalls;
		long_hold = hold;
		repeat (count)
			send_pair(random_pair());
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				out_stall <= 1'b0;
				long_hold = 1'b0;
			end else if ($urandom_range(0, 99) < stall_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		#2000000;
		$display("testbench NOT OK");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_pct   = 20;
		stall_pct = 20;
		send_pair(pair_of(0, 0, 0, 0, 0, 0));
		send_pair(pair_of(-32768, -32768, -32768, -32768, -32768, -32768));
		send_pair(pair_of(32767, 32767, 32767, 32767, 32767, 32767));
		send_pair(pair_of(32767, 0, 0, 32767, 0, 0));
		send_pair(pair_of(32767, 0, 0, 0, 32767, 0));
		send_pair(pair_of(-32768, 0, 0, 32767, 0, 0));
		send_pair(pair_of(-32768, -32768, 0, 16384, 16384, 0));
		send_pair(pair_of(-32768, -32768, -32768, 32767, 32767, 32767));
		send_pair(pair_of(0, 0, 32767, 0, 16384, 28378));
		send_pair(pair_of(23170, 23170, 0, 32767, 0, 0));
		send_pair(pair_of(0, 0, -32768, 0, 0, -32768));
		send_pair(pair_of(32767, -32768, 32767, -32768, 32767, -32768));
		send_pair(pair_of(-1, -1, -1, 1, 1, 1));
		send_pair(pair_of(1, 0, 0, 1, 0, 0));

		// dot just at and just past the forcing threshold
		write_margin(21'd65535);
		send_pair(pair_of(32767, 0, 0, 32767, 0, 0));
		write_margin(21'd65536);
		send_pair(pair_of(32767, 0, 0, 32767, 0, 0));
		write_margin(21'd0);
		send_pair(pair_of(0, 0, -32768, 0, 0, -32768));
		send_pair(pair_of(32767, 0, 0, 32767, 0, 0));
		send_pair(pair_of(32767, 32767, 32767, 32767, 32767, 32767));
		write_margin(21'd1048576);
		send_pair(pair_of(32767, 0, 0, 32767, 1424, 0));
		send_pair(pair_of(32767, 0, 0, 32767, 0, 0));

		random_phase(21'd1048576, 220, 20, 20, 1'b0);
		random_phase(21'($urandom_range(0, 1048576)), 220, 40, 10, 1'b1);
		random_phase(21'd0, 220, 5, 50, 1'b0);
		random_phase(21'($urandom_range(0, 1048576)), 220, 30, 30, 1'b0);
		random_phase(MARGIN_RESET, 220, 0, 0, 1'b0);

		drain();
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
